/* rtl/core/sm4_pkg.sv */
`timescale 1ns / 1ps

package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RIDX_W      = $clog2(ROUND_COUNT);

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_HIGH     = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW      = 2'd1;
    localparam logic [1:0] CFG_DECRYPT_MODE = 2'd2;

    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;

    typedef struct packed {
        logic [63:0] block_high;
        logic [63:0] block_low;
    } blk_in_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } blk_out_t;

    // Four cipher state words; index 0 is the oldest word X(i)
    typedef logic [3:0][31:0] word4_t;

    // All round keys, index i used by round i
    typedef logic [ROUND_COUNT-1:0][31:0] rk_bank_t;

    localparam logic [7:0] SBOX_TAB [0:255] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // Byte-wise S-box substitution of one word
    function automatic logic [31:0] subst_word(input logic [31:0] a);
        return {SBOX_TAB[a[31:24]], SBOX_TAB[a[23:16]],
                SBOX_TAB[a[15:8]],  SBOX_TAB[a[7:0]]};
    endfunction

    // Linear transform of the data rounds
    function automatic logic [31:0] lin_round(input logic [31:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    // Linear transform of the key schedule
    function automatic logic [31:0] lin_key(input logic [31:0] b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // CK byte j of word i is ((4*i + j) * 7) mod 256
    function automatic logic [31:0] ck_word(input logic [RIDX_W-1:0] i);
        logic [31:0] w;
        int          v;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            v = (4 * int'(i) + j) * 7;
            w = {w[23:0], v[7:0]};
        end
        return w;
    endfunction

endpackage

/* rtl/core/sm4_key_sched.sv */
`timescale 1ns / 1ps

module sm4_key_sched (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [1:0]                      cfg_index,
    input  logic [63:0]                     cfg_data,
    output logic                            busy,
    output sm4_pkg::rk_bank_t               round_keys
);

    logic [63:0]                    key_high_reg, key_high_next;
    logic [63:0]                    key_low_reg,  key_low_next;
    logic                           mode_reg,     mode_next;
    logic                           busy_reg,     busy_next;
    logic [sm4_pkg::RIDX_W-1:0]     cnt_reg,      cnt_next;
    sm4_pkg::word4_t                k_reg,        k_next;
    sm4_pkg::rk_bank_t              rk_reg;

    logic                           load;
    logic [31:0]                    new_key;
    logic [sm4_pkg::RIDX_W-1:0]     wr_addr;

    // Any write inside the register list restarts the expansion
    assign load = cfg_valid && (cfg_index == sm4_pkg::CFG_KEY_HIGH
                             || cfg_index == sm4_pkg::CFG_KEY_LOW
                             || cfg_index == sm4_pkg::CFG_DECRYPT_MODE);

    assign new_key = k_reg[0] ^ sm4_pkg::lin_key(sm4_pkg::subst_word(
                         k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ sm4_pkg::ck_word(cnt_reg)));

    // Decrypt stores keys in reverse order
    assign wr_addr = mode_reg ? (sm4_pkg::RIDX_W'(sm4_pkg::ROUND_COUNT - 1) - cnt_reg)
                              : cnt_reg;

    always_comb
    begin
        key_high_next = key_high_reg;
        key_low_next  = key_low_reg;
        mode_next     = mode_reg;
        busy_next     = busy_reg;
        cnt_next      = cnt_reg;
        k_next        = k_reg;
        if (load)
        begin
            case (cfg_index)
                sm4_pkg::CFG_KEY_HIGH:     key_high_next = cfg_data;
                sm4_pkg::CFG_KEY_LOW:      key_low_next  = cfg_data;
                sm4_pkg::CFG_DECRYPT_MODE: mode_next     = cfg_data[0];
                default:                   mode_next     = mode_reg;
            endcase
            k_next[0] = key_high_next[63:32] ^ sm4_pkg::FK0;
            k_next[1] = key_high_next[31:0]  ^ sm4_pkg::FK1;
            k_next[2] = key_low_next[63:32]  ^ sm4_pkg::FK2;
            k_next[3] = key_low_next[31:0]   ^ sm4_pkg::FK3;
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            k_next    = {new_key, k_reg[3], k_reg[2], k_reg[1]};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == sm4_pkg::RIDX_W'(sm4_pkg::ROUND_COUNT - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            mode_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            key_high_reg <= key_high_next;
            key_low_reg  <= key_low_next;
            mode_reg     <= mode_next;
            busy_reg     <= busy_next;
            cnt_reg      <= cnt_next;
        end
    end

    // Key words and the round key bank carry no reset
    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (busy_reg && !load)
        begin
            rk_reg[wr_addr] <= new_key;
        end
    end

    assign busy       = busy_reg;
    assign round_keys = rk_reg;

endmodule

/* rtl/core/sm4_round.sv */
`timescale 1ns / 1ps

module sm4_round (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                prev_valid,
    input  sm4_pkg::word4_t     prev_words,
    input  logic [31:0]         rk,
    output logic                valid,
    output sm4_pkg::word4_t     words
);

    logic               valid_reg;
    sm4_pkg::word4_t    words_reg, words_next;
    logic [31:0]        nx;

    assign nx = prev_words[0] ^ sm4_pkg::lin_round(sm4_pkg::subst_word(
                    prev_words[1] ^ prev_words[2] ^ prev_words[3] ^ rk));

    // Shift the window by one word and append the new one
    assign words_next = {nx, prev_words[3], prev_words[2], prev_words[1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            words_reg <= words_next;
        end
    end

    assign valid = valid_reg;
    assign words = words_reg;

endmodule

/* rtl/core/sm4_block_cipher.sv */
`timescale 1ns / 1ps

// SM4 block cipher, ECB, 128-bit key and block.
// Input channel: in_valid / in_stall with in_data (block_high, block_low);
// a word is taken at an edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with out_data (result_high,
// result_low); the receiver holds out_stall high to keep the word.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
// index 0 key_high, 1 key_low, 2 decrypt_mode (bit 0), others dropped.
// Each config write restarts key expansion: one round key per cycle, for
// all 32 round keys, during which in_stall stays high. Write config only while idle.
// Pipeline: one register per cipher round; the result of a taken word
// shows on out_valid from the last round register.
// Throughput: one word per cycle while out_stall and key expansion hold nothing up.
// Reset clears all valid bits and control; the round key bank holds
// nothing useful until the first config write has expanded.
// A stalled output freezes the whole round pipeline and raises in_stall;
// nothing is lost or repeated.
module sm4_block_cipher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sm4_pkg::blk_in_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sm4_pkg::blk_out_t   out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data
);

    logic                               key_busy;
    sm4_pkg::rk_bank_t                  round_keys;
    logic                               adv;
    logic [sm4_pkg::ROUND_COUNT:0]      stage_valid;
    sm4_pkg::word4_t                    stage_words [0:sm4_pkg::ROUND_COUNT];

    assign cfg_ready = 1'b1;

    sm4_key_sched u_key_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .busy       (key_busy),
        .round_keys (round_keys)
    );

    // Advance the whole pipeline unless the last stage holds a stalled word
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv || key_busy;

    assign stage_valid[0] = in_valid && !key_busy;
    assign stage_words[0] = {in_data.block_low[31:0], in_data.block_low[63:32],
                             in_data.block_high[31:0], in_data.block_high[63:32]};

    genvar r;
    generate
        for (r = 0; r < sm4_pkg::ROUND_COUNT; r++)
        begin : g_round
            sm4_round u_round (
                .clk        (clk),
                .rst_n      (rst_n),
                .adv        (adv),
                .prev_valid (stage_valid[r]),
                .prev_words (stage_words[r]),
                .rk         (round_keys[r]),
                .valid      (stage_valid[r+1]),
                .words      (stage_words[r+1])
            );
        end
    endgenerate

    // Output words in reverse: X35, X34, X33, X32
    assign out_valid            = stage_valid[sm4_pkg::ROUND_COUNT];
    assign out_data.result_high = {stage_words[sm4_pkg::ROUND_COUNT][3],
                                   stage_words[sm4_pkg::ROUND_COUNT][2]};
    assign out_data.result_low  = {stage_words[sm4_pkg::ROUND_COUNT][1],
                                   stage_words[sm4_pkg::ROUND_COUNT][0]};

endmodule
